FILE: hdl/tlpt_pkg.sv
package tlpt_pkg;

	// Default index widths of the directory and of one page table.
	localparam int DIR_INDEX_BITS_DEF   = 6;
	localparam int TABLE_INDEX_BITS_DEF = 6;

	localparam int OFFSET_BITS = 12;
	localparam int MODE_W      = 3;
	localparam int VA_W        = 24;
	localparam int ADDR_W      = 32;
	localparam int FLAG_W      = 12;
	localparam int STATUS_W    = 2;

	localparam logic [ADDR_W-1:0] FRAME_MASK  = 32'hFFFF_F000;
	localparam logic [FLAG_W-1:0] LOW_MASK    = 12'hFFF;
	localparam logic [FLAG_W-1:0] BIT_PRESENT = 12'h001;
	localparam logic [FLAG_W-1:0] BIT_WRITE   = 12'h002;

	typedef enum logic [MODE_W-1:0] {
		OP_MAP       = 3'd0,
		OP_UNMAP     = 3'd1,
		OP_TRANSLATE = 3'd2,
		OP_GET_FLAGS = 3'd3,
		OP_SET_FLAGS = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE     = 2'd0,
		STAT_ABSENT   = 2'd1,
		STAT_NO_FRAME = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EXEC  = 2'd1,
		ST_CLEAR = 2'd2,
		ST_RESP  = 2'd3
	} state_t;

endpackage

FILE: hdl/tlpt_ifs.sv
interface tlpt_req_if;
	logic                            valid;
	logic                            ready;
	logic [tlpt_pkg::MODE_W-1:0]     mode;
	logic [tlpt_pkg::VA_W-1:0]       virt_addr;
	logic [tlpt_pkg::ADDR_W-1:0]     phys_addr;
	logic [tlpt_pkg::FLAG_W-1:0]     page_flags;
	logic [tlpt_pkg::ADDR_W-1:0]     new_table_frame;

	modport source (
		output valid, mode, virt_addr, phys_addr, page_flags, new_table_frame,
		input  ready
	);
	modport sink (
		input  valid, mode, virt_addr, phys_addr, page_flags, new_table_frame,
		output ready
	);
endinterface

interface tlpt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [tlpt_pkg::ADDR_W-1:0]     phys_result;
	logic                            mapped;
	logic [tlpt_pkg::FLAG_W-1:0]     flags_result;
	logic [tlpt_pkg::STATUS_W-1:0]   status;
	logic                            invalidate;

	modport source (
		output valid, phys_result, mapped, flags_result, status, invalidate,
		input  ready
	);
	modport sink (
		input  valid, phys_result, mapped, flags_result, status, invalidate,
		output ready
	);
endinterface

FILE: hdl/two_level_page_table_engine_core.sv
// Each request is accepted in the idle state, which reads the directory and table memories;
// the execute state then finishes the read-modify-write on the table memory port and loads the
// response register. A map that creates a new page table sweeps it in the clear state first and
// answers from the response state. No new request is taken until the last response is loaded.
// Reset clears the control state and the directory valid bits, so every directory entry
// reads as not present; table memory contents are left as they are.
module two_level_page_table_engine_core #(
	parameter int DIR_INDEX_BITS   = tlpt_pkg::DIR_INDEX_BITS_DEF,
	parameter int TABLE_INDEX_BITS = tlpt_pkg::TABLE_INDEX_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tlpt_req_if.sink     req,
	tlpt_rsp_if.source   rsp
);

	localparam int DIR_DEPTH = 1 << DIR_INDEX_BITS;
	localparam int SLOT_W    = DIR_INDEX_BITS + TABLE_INDEX_BITS;
	localparam int ALL_DEPTH = 1 << SLOT_W;
	localparam int AW        = tlpt_pkg::ADDR_W;
	localparam int FW        = tlpt_pkg::FLAG_W;
	localparam int OW        = tlpt_pkg::OFFSET_BITS;

	// The directory and all page tables live in two synchronous memories. The table
	// that belongs to directory slot d occupies the rows {d, table index}.
	logic [AW-1:0] dir_mem [DIR_DEPTH];
	logic [AW-1:0] tab_mem [ALL_DEPTH];

	// Directory entries reset to zero through one valid bit each; an entry that has
	// never been written reads as not present.
	logic [DIR_DEPTH-1:0] dir_vld_q;

	tlpt_pkg::state_t  state_q, state_d;
	tlpt_pkg::mode_t   mode_q;
	logic [DIR_INDEX_BITS-1:0]   dix_q;
	logic [TABLE_INDEX_BITS-1:0] tix_q;
	logic [OW-1:0]               off_q;
	logic [AW-1:0]               pa_q;
	logic [FW-1:0]               fl_q;
	logic [AW-1:0]               frame_q;
	logic [TABLE_INDEX_BITS-1:0] clr_q;

	// Read stage outputs.
	logic [AW-1:0] dir_rdata_s1;
	logic          dir_vld_s1;
	logic [AW-1:0] tab_rdata_s1;

	// Response register.
	logic              out_vld_q;
	logic [AW-1:0]     phys_q;
	logic              mapped_q;
	logic [FW-1:0]     flags_q;
	tlpt_pkg::status_t status_q;
	logic              inval_q;

	// Request address decode. The virtual address is zero extended so that index
	// fields reaching above its top bit read zeros.
	logic [AW-1:0]               va_ext;
	logic [DIR_INDEX_BITS-1:0]   rd_dix;
	logic [TABLE_INDEX_BITS-1:0] rd_tix;

	assign va_ext = {{(AW - tlpt_pkg::VA_W){1'b0}}, req.virt_addr};
	assign rd_dix = va_ext[OW + TABLE_INDEX_BITS +: DIR_INDEX_BITS];
	assign rd_tix = va_ext[OW +: TABLE_INDEX_BITS];

	logic accept;
	logic rd_en;
	logic out_free;
	logic dir_ok;
	logic pte_ok;
	logic start_clear;
	logic [AW-1:0] pte_new;
	logic [AW-1:0] dir_new;

	assign accept   = req.valid && req.ready;
	assign out_free = !out_vld_q || rsp.ready;
	assign dir_ok   = dir_vld_s1 && dir_rdata_s1[0];
	assign pte_ok   = dir_ok && tab_rdata_s1[0];
	assign pte_new  = (pa_q & tlpt_pkg::FRAME_MASK) |
		{{(AW - FW){1'b0}}, (fl_q | tlpt_pkg::BIT_PRESENT)};
	assign dir_new  = (frame_q & tlpt_pkg::FRAME_MASK) |
		{{(AW - FW){1'b0}}, (fl_q | tlpt_pkg::BIT_PRESENT | tlpt_pkg::BIT_WRITE)};
	// A map into an absent directory slot with a frame available builds a new table.
	assign start_clear = (mode_q == tlpt_pkg::OP_MAP) && !dir_ok && (frame_q != '0);

	// Control outputs of the state machine.
	logic              dir_we;
	logic              tab_we;
	logic [SLOT_W-1:0] tab_waddr;
	logic [AW-1:0]     tab_wdata;
	logic              out_load;
	logic [AW-1:0]     res_phys;
	logic              res_mapped;
	logic [FW-1:0]     res_flags;
	tlpt_pkg::status_t res_status;
	logic              res_inval;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tlpt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = tlpt_pkg::ST_EXEC;
				end
			end
			tlpt_pkg::ST_EXEC: begin
				if (start_clear) begin
					state_d = tlpt_pkg::ST_CLEAR;
				end else if (out_free) begin
					state_d = tlpt_pkg::ST_IDLE;
				end
			end
			tlpt_pkg::ST_CLEAR: begin
				if (&clr_q) begin
					state_d = tlpt_pkg::ST_RESP;
				end
			end
			tlpt_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = tlpt_pkg::ST_IDLE;
				end
			end
			default: state_d = tlpt_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine: memory controls and the result to register.
	always_comb begin
		req.ready  = 1'b0;
		rd_en      = 1'b0;
		dir_we     = 1'b0;
		tab_we     = 1'b0;
		tab_waddr  = {dix_q, tix_q};
		tab_wdata  = '0;
		out_load   = 1'b0;
		res_phys   = '0;
		res_mapped = 1'b0;
		res_flags  = '0;
		res_status = tlpt_pkg::STAT_DONE;
		res_inval  = 1'b0;
		case (state_q)
			tlpt_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				rd_en     = req.valid;
			end
			tlpt_pkg::ST_EXEC: begin
				if (start_clear) begin
					dir_we = 1'b1;
				end else if (out_free) begin
					out_load = 1'b1;
					case (mode_q)
						tlpt_pkg::OP_MAP: begin
							if (dir_ok) begin
								tab_we    = 1'b1;
								tab_wdata = pte_new;
								res_inval = 1'b1;
							end else begin
								res_status = tlpt_pkg::STAT_NO_FRAME;
							end
						end
						tlpt_pkg::OP_UNMAP: begin
							if (pte_ok) begin
								tab_we    = 1'b1;
								res_inval = 1'b1;
							end else begin
								res_status = tlpt_pkg::STAT_ABSENT;
							end
						end
						tlpt_pkg::OP_TRANSLATE: begin
							if (pte_ok) begin
								res_phys = (tab_rdata_s1 & tlpt_pkg::FRAME_MASK) +
									{{(AW - OW){1'b0}}, off_q};
								res_mapped = (res_phys != '0);
							end else begin
								res_status = tlpt_pkg::STAT_ABSENT;
							end
						end
						tlpt_pkg::OP_GET_FLAGS: begin
							if (dir_ok) begin
								res_flags = tab_rdata_s1[FW-1:0];
							end else begin
								res_status = tlpt_pkg::STAT_ABSENT;
							end
						end
						tlpt_pkg::OP_SET_FLAGS: begin
							if (pte_ok) begin
								tab_we    = 1'b1;
								tab_wdata = (tab_rdata_s1 & tlpt_pkg::FRAME_MASK) |
									{{(AW - FW){1'b0}}, fl_q};
								res_inval = 1'b1;
							end else begin
								res_status = tlpt_pkg::STAT_ABSENT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			tlpt_pkg::ST_CLEAR: begin
				// Sweep the new table; the mapped slot takes the new page entry directly.
				tab_we    = 1'b1;
				tab_waddr = {dix_q, clr_q};
				tab_wdata = (clr_q == tix_q) ? pte_new : '0;
			end
			tlpt_pkg::ST_RESP: begin
				out_load  = out_free;
				res_inval = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Directory memory with its reset valid bits.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			dir_rdata_s1 <= dir_mem[rd_dix];
			dir_vld_s1   <= dir_vld_q[rd_dix];
		end
		if (dir_we) begin
			dir_mem[dix_q] <= dir_new;
		end
	end

	// Table memory.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			tab_rdata_s1 <= tab_mem[{rd_dix, rd_tix}];
		end
		if (tab_we) begin
			tab_mem[tab_waddr] <= tab_wdata;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= tlpt_pkg::mode_t'(req.mode);
			dix_q   <= rd_dix;
			tix_q   <= rd_tix;
			off_q   <= va_ext[OW-1:0];
			pa_q    <= req.phys_addr;
			fl_q    <= req.page_flags & tlpt_pkg::LOW_MASK;
			frame_q <= req.new_table_frame;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			phys_q   <= res_phys;
			mapped_q <= res_mapped;
			flags_q  <= res_flags;
			status_q <= res_status;
			inval_q  <= res_inval;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlpt_pkg::ST_IDLE;
			dir_vld_q <= '0;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (dir_we) begin
				dir_vld_q[dix_q] <= 1'b1;
			end
			if (state_q == tlpt_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.phys_result  = phys_q;
	assign rsp.mapped       = mapped_q;
	assign rsp.flags_result = flags_q;
	assign rsp.status       = status_q;
	assign rsp.invalidate   = inval_q;

`ifndef SYNTHESIS
	// A new response only ever comes out of the execute or response state.
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == tlpt_pkg::ST_EXEC ||
			$past(state_q) == tlpt_pkg::ST_RESP))
		else $error("response loaded outside execute or response state");

	// The table memory is never written while a new request may be read.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		tab_we |-> state_q != tlpt_pkg::ST_IDLE)
		else $error("table write while idle");

	// An accepted request always goes to the execute state next.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == tlpt_pkg::ST_EXEC)
		else $error("accepted request did not reach execute");

	// A flush request is only raised for a completed change.
	a_inval_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.invalidate) |-> rsp.status == tlpt_pkg::STAT_DONE)
		else $error("invalidate with failing status");

	// A mapped translation carries a nonzero address.
	a_mapped_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.mapped) |-> rsp.phys_result != '0)
		else $error("mapped with zero physical result");
`endif

endmodule
